[src/pva_pkg.sv]
// Shared types and constants of the voice allocator.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int unsigned VOICE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned PICK_W     = 5;   // holds 0..16 picks
  localparam int unsigned MAX_PICKS  = 16;
  localparam logic [6:0]  PEDAL_THRESH = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L0_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L1_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIG   = 3'd5;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_PEDAL    = 2'd2,
    CMD_RESET    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NEW_NOTE = 2'd0,
    KIND_CLOSE    = 2'd1,
    KIND_RETRIG   = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_PLAY = 2'd1,
    ST_SUST = 2'd2,
    ST_PICK = 2'd3
  } vstat_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_PICK_SCAN,
    OP_PICK_COMMIT,
    OP_NEW_NOTE,
    OP_RETRIG_A,
    OP_RETRIG_B,
    OP_REL_SCAN,
    OP_CLR_SCAN,
    OP_PEDAL_SET,
    OP_FINISH
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PICK_SCAN,
    S_PICK_COMMIT,
    S_NOTE_CHK,
    S_NEW,
    S_RTA,
    S_RTB,
    S_REL,
    S_CLR,
    S_FINISH
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic               layer;
    logic [VOICE_W-1:0] voice;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic               lfo;
  } res_t;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic pedal_hi;
    logic on_skip;
    logic clr_skip;
    logic scan_last;
    logic pick_last;
    logic np_zero;
    logic note_last;
  } sts_t;

endpackage

[src/pva_ctrl.sv]
// Sequencer of the voice allocator: steps one request through its phases.
`timescale 1ns / 1ps
module pva_ctrl
  import pva_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic step_ok_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_NOTE_ON: begin
            if (sts_i.on_skip) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.op = OP_START;
              state_d  = S_PICK_SCAN;
            end
          end
          CMD_NOTE_OFF: begin
            cmd_o.op = OP_START;
            state_d  = S_REL;
          end
          CMD_PEDAL: begin
            if (sts_i.pedal_hi) begin
              cmd_o.op = OP_PEDAL_SET;
              state_d  = S_FINISH;
            end else if (sts_i.clr_skip) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.op = OP_START;
              state_d  = S_CLR;
            end
          end
          default: begin
            if (sts_i.clr_skip) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.op = OP_START;
              state_d  = S_CLR;
            end
          end
        endcase
      end
      S_PICK_SCAN: begin
        cmd_o.op = OP_PICK_SCAN;
        if (sts_i.scan_last) state_d = S_PICK_COMMIT;
      end
      S_PICK_COMMIT: begin
        if (step_ok_i) begin
          cmd_o.op = OP_PICK_COMMIT;
          state_d  = sts_i.pick_last ? S_NOTE_CHK : S_PICK_SCAN;
        end
      end
      S_NOTE_CHK: begin
        state_d = sts_i.np_zero ? S_FINISH : S_NEW;
      end
      S_NEW: begin
        if (step_ok_i) begin
          cmd_o.op = OP_NEW_NOTE;
          state_d  = S_RTA;
        end
      end
      S_RTA: begin
        if (step_ok_i) begin
          cmd_o.op = OP_RETRIG_A;
          state_d  = S_RTB;
        end
      end
      S_RTB: begin
        if (step_ok_i) begin
          cmd_o.op = OP_RETRIG_B;
          state_d  = sts_i.note_last ? S_FINISH : S_NEW;
        end
      end
      S_REL: begin
        if (step_ok_i) begin
          cmd_o.op = OP_REL_SCAN;
          if (sts_i.scan_last) state_d = S_FINISH;
        end
      end
      S_CLR: begin
        if (step_ok_i) begin
          cmd_o.op = OP_CLR_SCAN;
          if (sts_i.scan_last) state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (step_ok_i) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[src/pva_dp.sv]
// Datapath: configuration, voice table, oldest-voice scan and result forming.
`timescale 1ns / 1ps
module pva_dp
  import pva_pkg::*;
#(
  parameter int unsigned VOICES_PER_LAYER = 8,
  parameter int unsigned STAMP_BITS       = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_e                  in_cmd_i,
  input  logic                  in_layer_i,
  input  logic [6:0]            in_note_i,
  input  logic [6:0]            in_vel_i,
  input  logic [6:0]            in_pedal_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  emit_o,
  output res_t                  res_o,
  output logic                  flush_o
);

  localparam int unsigned VPL = VOICES_PER_LAYER;
  localparam int unsigned I_W = (VPL > 1) ? $clog2(VPL) : 1;
  localparam logic [I_W-1:0] I_LAST = I_W'(VPL - 1);

  // Configuration registers
  logic [2:0] mode_a_q;
  logic [1:0] mode_b_q;
  logic       merge_q;
  logic [1:0] en_q;
  logic [3:0] mask_q;

  // Latched request
  cmd_e       in_cmd_q;
  logic       in_layer_q;
  logic [6:0] in_note_q;
  logic [6:0] in_vel_q;
  logic       ped_hi_q;

  // Voice table
  vstat_e                status_q [2][VPL];
  logic [6:0]            vnote_q  [2][VPL];
  logic [6:0]            vvel_q   [2][VPL];
  logic [STAMP_BITS-1:0] stamp_q  [2][VPL];
  logic [1:0]            pedal_q;
  logic [STAMP_BITS-1:0] cnt_q;

  // Scan position and best candidates (free / not yet picked)
  logic                  scan_l_q;
  logic [I_W-1:0]        scan_i_q;
  logic                  bf_v_q, bn_v_q;
  logic                  bf_l_q, bn_l_q;
  logic [I_W-1:0]        bf_i_q, bn_i_q;
  logic [STAMP_BITS-1:0] bf_s_q, bn_s_q;

  // Pick list
  logic [PICK_W-1:0] pick_k_q, np_q, k_q;
  logic              pk_l_q [MAX_PICKS];
  logic [I_W-1:0]    pk_i_q [MAX_PICKS];

  logic [2:0]            code;
  logic [PICK_W-1:0]     count;
  vstat_e                st_cur, sel_st;
  logic [STAMP_BITS-1:0] s_cur;
  logic                  scope_pick, scope_rel, sus, rel_hit, clr_hit;
  logic                  sel_any, sel_l, pk_l, scan_last;
  logic [I_W-1:0]        sel_i, pk_i;

  // Request decode and scan terms
  always_comb begin
    code = (in_layer_q && !merge_q) ? {1'b0, mode_b_q} : mode_a_q;
    count = (code <= 3'd4) ? PICK_W'(1 << code) : '0;
    st_cur = status_q[scan_l_q][scan_i_q];
    s_cur  = stamp_q[scan_l_q][scan_i_q];
    scope_pick = merge_q ? en_q[scan_l_q] : (scan_l_q == in_layer_q);
    scope_rel  = merge_q | (scan_l_q == in_layer_q);
    sus = merge_q ? pedal_q[0] : pedal_q[in_layer_q];
    rel_hit = scope_rel && (st_cur == ST_PLAY) &&
              (vnote_q[scan_l_q][scan_i_q] == in_note_q);
    clr_hit = scope_rel && ((in_cmd_q != CMD_PEDAL) || (st_cur == ST_SUST));
    sel_any = bf_v_q | bn_v_q;
    sel_l   = bf_v_q ? bf_l_q : bn_l_q;
    sel_i   = bf_v_q ? bf_i_q : bn_i_q;
    sel_st  = status_q[sel_l][sel_i];
    pk_l    = pk_l_q[k_q[3:0]];
    pk_i    = pk_i_q[k_q[3:0]];
    scan_last = scan_l_q && (scan_i_q == I_LAST);
  end

  // Status toward the sequencer
  always_comb begin
    sts_o.cmd       = in_cmd_q;
    sts_o.pedal_hi  = ped_hi_q;
    sts_o.on_skip   = (merge_q && in_layer_q) || (count == '0);
    sts_o.clr_skip  = merge_q && in_layer_q;
    sts_o.scan_last = scan_last;
    sts_o.pick_last = (PICK_W'(pick_k_q + 1'b1) == count);
    sts_o.np_zero   = (np_q == '0);
    sts_o.note_last = (PICK_W'(k_q + 1'b1) == np_q);
  end

  // Result forming
  always_comb begin
    emit_o  = 1'b0;
    flush_o = 1'b0;
    res_o   = '0;
    case (cmd_i.op)
      OP_PICK_COMMIT: begin
        if (!sel_any) begin
          emit_o     = 1'b1;
          res_o.kind = KIND_ERROR;
        end else begin
          emit_o      = (sel_st == ST_PLAY) || (sel_st == ST_SUST);
          res_o.kind  = KIND_CLOSE;
          res_o.layer = sel_l;
          res_o.voice = VOICE_W'(sel_i);
        end
      end
      OP_NEW_NOTE: begin
        emit_o         = 1'b1;
        res_o.kind     = KIND_NEW_NOTE;
        res_o.layer    = pk_l;
        res_o.voice    = VOICE_W'(pk_i);
        res_o.note     = in_note_q;
        res_o.velocity = in_vel_q;
      end
      OP_RETRIG_A, OP_RETRIG_B: begin
        res_o.lfo   = (cmd_i.op == OP_RETRIG_B);
        emit_o      = mask_q[{pk_l, res_o.lfo}];
        res_o.kind  = KIND_RETRIG;
        res_o.layer = pk_l;
      end
      OP_REL_SCAN, OP_CLR_SCAN: begin
        emit_o      = (cmd_i.op == OP_REL_SCAN) ? (rel_hit && !sus) : clr_hit;
        res_o.kind  = KIND_CLOSE;
        res_o.layer = scan_l_q;
        res_o.voice = VOICE_W'(scan_i_q);
      end
      OP_FINISH: flush_o = 1'b1;
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_a_q <= '0;
      mode_b_q <= '0;
      merge_q  <= 1'b0;
      en_q     <= 2'b11;
      mask_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE_A: mode_a_q <= cfg_data_i[2:0];
        REG_MODE_B: mode_b_q <= cfg_data_i[1:0];
        REG_MERGE:  merge_q  <= cfg_data_i[0];
        REG_L0_EN:  en_q[0]  <= cfg_data_i[0];
        REG_L1_EN:  en_q[1]  <= cfg_data_i[0];
        REG_RETRIG: mask_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      in_cmd_q   <= in_cmd_i;
      in_layer_q <= in_layer_i;
      in_note_q  <= in_note_i;
      in_vel_q   <= in_vel_i;
      ped_hi_q   <= (in_pedal_i >= PEDAL_THRESH);
    end
  end

  // Pick list storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PICK_COMMIT && sel_any) begin
      pk_l_q[np_q[3:0]] <= sel_l;
      pk_i_q[np_q[3:0]] <= sel_i;
    end
  end

  // Voice table, scan and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < VPL; i++) begin
          status_q[l][i] <= ST_FREE;
          vnote_q[l][i]  <= '0;
          vvel_q[l][i]   <= '0;
          stamp_q[l][i]  <= '0;
        end
      end
      pedal_q  <= '0;
      cnt_q    <= '0;
      scan_l_q <= 1'b0;
      scan_i_q <= '0;
      bf_v_q   <= 1'b0;
      bn_v_q   <= 1'b0;
      bf_l_q   <= 1'b0;
      bn_l_q   <= 1'b0;
      bf_i_q   <= '0;
      bn_i_q   <= '0;
      bf_s_q   <= '0;
      bn_s_q   <= '0;
      pick_k_q <= '0;
      np_q     <= '0;
      k_q      <= '0;
    end else begin
      // scan position steps in every scanning op
      if (cmd_i.op == OP_PICK_SCAN || cmd_i.op == OP_REL_SCAN ||
          cmd_i.op == OP_CLR_SCAN) begin
        if (scan_i_q == I_LAST) begin
          scan_i_q <= '0;
          scan_l_q <= ~scan_l_q;
        end else begin
          scan_i_q <= I_W'(scan_i_q + 1'b1);
        end
      end
      case (cmd_i.op)
        OP_START: begin
          scan_l_q <= 1'b0;
          scan_i_q <= '0;
          bf_v_q   <= 1'b0;
          bn_v_q   <= 1'b0;
          pick_k_q <= '0;
          np_q     <= '0;
          k_q      <= '0;
        end
        OP_PICK_SCAN: begin
          if (scope_pick) begin
            if (st_cur == ST_FREE && (!bf_v_q || s_cur < bf_s_q)) begin
              bf_v_q <= 1'b1;
              bf_l_q <= scan_l_q;
              bf_i_q <= scan_i_q;
              bf_s_q <= s_cur;
            end
            if (st_cur != ST_PICK && (!bn_v_q || s_cur < bn_s_q)) begin
              bn_v_q <= 1'b1;
              bn_l_q <= scan_l_q;
              bn_i_q <= scan_i_q;
              bn_s_q <= s_cur;
            end
          end
        end
        OP_PICK_COMMIT: begin
          if (sel_any) begin
            status_q[sel_l][sel_i] <= ST_PICK;
            np_q <= PICK_W'(np_q + 1'b1);
          end
          pick_k_q <= PICK_W'(pick_k_q + 1'b1);
          bf_v_q   <= 1'b0;
          bn_v_q   <= 1'b0;
        end
        OP_NEW_NOTE: begin
          cnt_q <= STAMP_BITS'(cnt_q + 1'b1);
          status_q[pk_l][pk_i] <= ST_PLAY;
          vnote_q[pk_l][pk_i]  <= in_note_q;
          vvel_q[pk_l][pk_i]   <= in_vel_q;
          stamp_q[pk_l][pk_i]  <= STAMP_BITS'(cnt_q + 1'b1);
        end
        OP_RETRIG_B: k_q <= PICK_W'(k_q + 1'b1);
        OP_REL_SCAN: begin
          if (rel_hit) status_q[scan_l_q][scan_i_q] <= sus ? ST_SUST : ST_FREE;
        end
        OP_CLR_SCAN: begin
          if (clr_hit) status_q[scan_l_q][scan_i_q] <= ST_FREE;
          if (scan_last) begin
            for (int l = 0; l < 2; l++) begin
              if (merge_q || (l[0] == in_layer_q)) pedal_q[l] <= 1'b0;
            end
          end
        end
        OP_PEDAL_SET: pedal_q[in_layer_q] <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[src/pva_out.sv]
// Result staging: holds one result back to mark the final one, then registers it.
`timescale 1ns / 1ps
module pva_out
  import pva_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic emit_i,
  input  res_t res_i,
  input  logic flush_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t out_res_o,
  output logic out_last_o,
  output logic step_ok_o
);

  logic hold_v_q, out_v_q, out_last_q;
  res_t hold_q, out_q;

  assign step_ok_o   = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if ((emit_i || flush_i) && hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (emit_i) begin
        hold_v_q <= 1'b1;
      end else if (flush_i) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if ((emit_i || flush_i) && hold_v_q) begin
      out_q      <= hold_q;
      out_last_q <= flush_i;
    end
    if (emit_i) hold_q <= res_i;
  end

endmodule

[src/poly_voice_allocator_top.sv]
// Two-layer voice allocator: note-on claims oldest free or stolen voices.
// One request is worked at a time. For a note-on, each pick walks the whole
// voice table once, then each picked voice is started and its retrigger steps
// run; note-off, pedal release and layer reset walk the table once. Dispatch
// and finish steps are added, and a stalled result output holds the sequence.
// No clearing pass runs after reset.
`timescale 1ns / 1ps
module poly_voice_allocator_top
  import pva_pkg::*;
#(
  parameter int unsigned VOICES_PER_LAYER = 8,
  parameter int unsigned STAMP_BITS       = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // layer, note, velocity, pedal_value
  input  logic [1:0]            s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // out_layer, voice, out_note, out_velocity, lfo
  output logic [1:0]            m_axis_tuser,  // kind
  output logic                  m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;
  res_t res, out_res;
  logic emit, flush, step_ok;

  pva_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .step_ok_i  (step_ok),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  pva_dp #(
    .VOICES_PER_LAYER (VOICES_PER_LAYER),
    .STAMP_BITS       (STAMP_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_cmd_i   (cmd_e'(s_axis_tuser)),
    .in_layer_i (s_axis_tdata[0]),
    .in_note_i  (s_axis_tdata[7:1]),
    .in_vel_i   (s_axis_tdata[14:8]),
    .in_pedal_i (s_axis_tdata[21:15]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .emit_o     (emit),
    .res_o      (res),
    .flush_o    (flush)
  );

  pva_out u_out (
    .clk_i,
    .rst_ni,
    .emit_i      (emit),
    .res_i       (res),
    .flush_i     (flush),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast),
    .step_ok_o   (step_ok)
  );

  // Output packing
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'd0, out_res.lfo, out_res.velocity, out_res.note,
                         out_res.voice, out_res.layer};

endmodule

[sim/pva_checker.sv]
// Voice allocator scoreboard: tracks allocation state, predicts results, compares outputs.
`timescale 1ns / 1ps
module pva_checker
  import pva_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [23:0]           m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fail_count,
  output int                    pending_count
);
  localparam int NV = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic        layer;
    logic [2:0]  voice;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic        lfo;
    logic        last;
  } msg_t;

  // allocator mirror
  vstat_e      vst [NV];
  logic [6:0]  vnote [NV];
  logic [31:0] vstamp [NV];
  logic        pedal [2];
  logic [31:0] stamp_ctr;
  logic [2:0]  mode_a;
  logic [1:0]  mode_b;
  logic        merge, en0, en1;
  logic [3:0]  retrig;

  msg_t expected_q[$];
  msg_t step_q[$];

  assign pending_count = expected_q.size();

  function automatic void push_msg(kind_e k, int l, int v, int n, int vel, int lf);
    msg_t m;
    m = '{kind: k, layer: 1'(l), voice: 3'(v), note: 7'(n), vel: 7'(vel),
          lfo: 1'(lf), last: 1'b0};
    step_q.insert(step_q.size(), m);
  endfunction

  function automatic void close_voice(int v);
    vst[v] = ST_FREE;
    push_msg(KIND_CLOSE, v / 8, v % 8, 0, 0, 0);
  endfunction

  function automatic bit in_scan(int l, bit merged, int layer);
    if (merged) return l == 0 ? en0 : en1;
    return l == layer;
  endfunction

  function automatic int oldest_voice(bit merged, int layer);
    int best;
    bit ok;
    best = -1;
    for (int pass = 0; pass < 2 && best < 0; pass++)
      for (int l = 0; l < 2; l++) begin
        if (!in_scan(l, merged, layer)) continue;
        for (int i = 0; i < 8; i++) begin
          ok = pass == 0 ? vst[l*8+i] == ST_FREE : vst[l*8+i] != ST_PICK;
          if (ok && (best < 0 || vstamp[l*8+i] < vstamp[best])) best = l*8+i;
        end
      end
    return best;
  endfunction

  function automatic void allocate_note(int layer, logic [6:0] n, logic [6:0] vel);
    int picked[$];
    int cnt, v;
    logic [2:0] code;
    cnt = 0;
    if (merge && layer == 1) return;
    code = layer == 0 ? mode_a : {1'b0, mode_b};
    if (code <= 4) cnt = 1 << code;
    for (int k = 0; k < cnt; k++) begin
      v = oldest_voice(merge, layer);
      if (v < 0) begin
        push_msg(KIND_ERROR, 0, 0, 0, 0, 0);
        continue;
      end
      if (vst[v] == ST_PLAY || vst[v] == ST_SUST) close_voice(v);
      vst[v] = ST_PICK;
      picked.insert(picked.size(), v);
    end
    foreach (picked[k]) begin
      v = picked[k];
      stamp_ctr = stamp_ctr + 32'd1;
      vst[v] = ST_PLAY;
      vnote[v] = n;
      vstamp[v] = stamp_ctr;
      push_msg(KIND_NEW_NOTE, v / 8, v % 8, n, vel, 0);
      for (int lf = 0; lf < 2; lf++)
        if (retrig[2*(v/8)+lf]) push_msg(KIND_RETRIG, v / 8, 0, 0, 0, lf);
    end
  endfunction

  function automatic void release_note(int l, logic [6:0] n, bit sus);
    for (int i = 0; i < 8; i++)
      if (vst[l*8+i] == ST_PLAY && vnote[l*8+i] == n) begin
        if (sus) vst[l*8+i] = ST_SUST;
        else close_voice(l*8+i);
      end
  endfunction

  function automatic void clear_voices(int l, bit only_sus);
    for (int i = 0; i < 8; i++)
      if (!only_sus || vst[l*8+i] == ST_SUST) close_voice(l*8+i);
    pedal[l] = 1'b0;
  endfunction

  function automatic void clear_span(int layer, bit only_sus);
    if (merge) begin
      if (layer == 0) begin
        clear_voices(0, only_sus);
        clear_voices(1, only_sus);
      end
    end else clear_voices(layer, only_sus);
  endfunction

  function automatic void predict_event(cmd_e c, int layer, logic [6:0] n,
                                        logic [6:0] vel, logic [6:0] pv);
    step_q.delete();
    case (c)
      CMD_NOTE_ON: allocate_note(layer, n, vel);
      CMD_NOTE_OFF: begin
        if (merge) begin
          release_note(0, n, pedal[0]);
          release_note(1, n, pedal[0]);
        end else release_note(layer, n, pedal[layer]);
      end
      CMD_PEDAL: begin
        if (pv >= PEDAL_THRESH) pedal[layer] = 1'b1;
        else clear_span(layer, 1'b1);
      end
      default: clear_span(layer, 1'b0);
    endcase
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    foreach (step_q[k]) expected_q.insert(expected_q.size(), step_q[k]);
  endfunction

  msg_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NV; v++) begin
        vst[v] = ST_FREE; vnote[v] = '0; vstamp[v] = '0;
      end
      pedal[0] = 1'b0; pedal[1] = 1'b0; stamp_ctr = '0;
      mode_a = '0; mode_b = '0; merge = 1'b0; en0 = 1'b1; en1 = 1'b1; retrig = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_we_i)
        case (cfg_idx_i)
          REG_MODE_A: mode_a = cfg_data_i[2:0];
          REG_MODE_B: mode_b = cfg_data_i[1:0];
          REG_MERGE:  merge  = cfg_data_i[0];
          REG_L0_EN:  en0    = cfg_data_i[0];
          REG_L1_EN:  en1    = cfg_data_i[0];
          REG_RETRIG: retrig = cfg_data_i[3:0];
          default: ;
        endcase
      // result compare
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tuser, layer: m_axis_tdata[0], voice: m_axis_tdata[3:1],
                note: m_axis_tdata[10:4], vel: m_axis_tdata[17:11],
                lfo: m_axis_tdata[18], last: m_axis_tlast};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result got=%p", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected=%p actual=%p", $time, want, got);
            fail_count++;
          end
        end
      end
      // request prediction
      if (s_axis_tvalid && s_axis_tready)
        predict_event(cmd_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[7:1],
                      s_axis_tdata[14:8], s_axis_tdata[21:15]);
    end
  end
endmodule

[sim/tb.sv]
// Top of the voice allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import pva_pkg::*;

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [23:0]           s_axis_tdata;   // layer, note, velocity, pedal_value
  logic [1:0]            s_axis_tuser;   // command
  logic                  m_axis_tvalid, m_axis_tready;
  logic [23:0]           m_axis_tdata;   // out_layer, voice, out_note, out_velocity, lfo
  logic [1:0]            m_axis_tuser;   // kind
  logic                  m_axis_tlast;
  int                    fail_count, pending_count;

  poly_voice_allocator_top DUT (.*);
  pva_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 3) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // output stall pattern
  initial begin
    int g;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  // valid stays up after the accept until the next gap or drain drops it
  task automatic send_event(cmd_e c, int l, int n, int v, int p, bit burst = 0);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {2'b00, 7'(p), 7'(v), 7'(n), 1'(l)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_event(CMD_NOTE_ON, $urandom_range(0, 1), $urandom_range(0, 127),
                 $urandom_range(0, 127), 0, $urandom_range(0, 3) == 0);
    else if (r < 75)
      send_event(CMD_NOTE_OFF, $urandom_range(0, 1), $urandom_range(60, 67),
                 $urandom_range(0, 127), $urandom_range(0, 127));
    else if (r < 93)
      send_event(CMD_PEDAL, $urandom_range(0, 1), $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 127));
    else
      send_event(CMD_RESET, $urandom_range(0, 1), $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  task automatic random_config();
    write_reg(REG_MODE_A, $urandom_range(0, 7));
    write_reg(REG_MODE_B, $urandom_range(0, 3));
    write_reg(REG_MERGE, $urandom_range(0, 1));
    write_reg(REG_L0_EN, ($urandom_range(0, 5) != 0) ? 1 : 0);
    write_reg(REG_L1_EN, ($urandom_range(0, 5) != 0) ? 1 : 0);
    write_reg(REG_RETRIG, $urandom_range(0, 15));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = CMD_NOTE_ON;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: defaults, field extremes, stealing
    send_event(CMD_NOTE_ON, 0, 127, 127, 127);
    send_event(CMD_NOTE_ON, 1, 0, 0, 0);
    for (int i = 0; i < 9; i++) send_event(CMD_NOTE_ON, 0, 60 + (i % 2), 64, 0);
    send_event(CMD_PEDAL, 0, 0, 0, 64);
    send_event(CMD_NOTE_OFF, 0, 60, 0, 0);
    send_event(CMD_PEDAL, 0, 0, 0, 63);
    send_event(CMD_NOTE_OFF, 1, 0, 0, 0);
    send_event(CMD_RESET, 1, 0, 0, 0);
    drain();
    // widest claims, all retriggers, merge pooling
    write_reg(REG_MODE_A, 4);
    write_reg(REG_MODE_B, 3);
    write_reg(REG_RETRIG, 15);
    send_event(CMD_NOTE_ON, 1, 5, 9, 0);
    send_event(CMD_NOTE_ON, 0, 7, 3, 0);
    drain();
    write_reg(REG_MERGE, 1);
    send_event(CMD_NOTE_ON, 0, 42, 100, 0);
    send_event(CMD_NOTE_ON, 1, 42, 100, 0);
    send_event(CMD_PEDAL, 1, 0, 0, 10);
    send_event(CMD_RESET, 1, 0, 0, 0);
    send_event(CMD_NOTE_OFF, 1, 42, 0, 0);
    send_event(CMD_RESET, 0, 0, 0, 0);
    drain();
    // no layer enabled, then unused mode code
    write_reg(REG_L0_EN, 0);
    write_reg(REG_L1_EN, 0);
    write_reg(REG_MODE_A, 2);
    send_event(CMD_NOTE_ON, 0, 1, 1, 0);
    drain();
    write_reg(REG_MODE_A, 7);
    send_event(CMD_NOTE_ON, 0, 1, 1, 0);
    drain();

    // random phases, each with its own settings; the sender drains between
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      for (int i = 0; i < 22; i++) random_event();
      drain();
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
src/pva_pkg.sv
src/pva_ctrl.sv
src/pva_dp.sv
src/pva_out.sv
src/poly_voice_allocator_top.sv
sim/pva_checker.sv
sim/tb.sv
